FILE: sv/unix_time_to_calendar_defines.svh
// Assertion helpers used by the block's top-level RTL file.
`ifndef UNIX_TIME_TO_CALENDAR_DEFINES_SVH
`define UNIX_TIME_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UTTC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uttc: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define UTTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uttc: next-cycle check failed");

`endif

FILE: sv/uttc_pkg.sv
package uttc_pkg;

  localparam logic [32:0] SECS_COMMON_YEAR = 33'd31536000;
  localparam logic [32:0] SECS_LEAP_YEAR   = 33'd31622400;
  localparam logic [16:0] SECS_DAY         = 17'd86400;
  localparam logic [16:0] SECS_HOUR        = 17'd3600;
  localparam logic [16:0] SECS_MINUTE      = 17'd60;
  localparam logic [16:0] DAYS_WEEK        = 17'd7;
  localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
  localparam logic [11:0] CENTURY_NON_LEAP = 12'd2100;
  // 1970-01-01 was a Thursday; Monday is 0.
  localparam logic [2:0]  EPOCH_WEEKDAY    = 3'd3;

  // Divide phases of the shared compare-subtract unit.
  localparam logic [1:0] PH_DAY  = 2'd0;
  localparam logic [1:0] PH_HOUR = 2'd1;
  localparam logic [1:0] PH_MIN  = 2'd2;
  localparam logic [1:0] PH_DOW  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       year_step;
    logic       div_step;
    logic       div_first;
    logic       div_end;
    logic [1:0] div_phase;
    logic [3:0] div_shift;
    logic       month_step;
    logic       out_load;
  } uttc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } uttc_sts_t;

  // Years seen here run 1970..2106, so 2100 is the only century to exclude.
  function automatic logic is_leap(input logic [11:0] year);
    is_leap = (year[1:0] == 2'b00) && (year != CENTURY_NON_LEAP);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    unique case (month)
      4'd2:                      month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [16:0] div_const(input logic [1:0] phase);
    unique case (phase)
      PH_DAY:  div_const = SECS_DAY;
      PH_HOUR: div_const = SECS_HOUR;
      PH_MIN:  div_const = SECS_MINUTE;
      default: div_const = DAYS_WEEK;
    endcase
  endfunction

  // Highest quotient bit of each phase: days < 512, hours < 32, minutes < 64,
  // weeks in a year < 64.
  function automatic logic [3:0] div_top(input logic [1:0] phase);
    unique case (phase)
      PH_DAY:  div_top = 4'd8;
      PH_HOUR: div_top = 4'd4;
      PH_MIN:  div_top = 4'd5;
      default: div_top = 4'd5;
    endcase
  endfunction

endpackage

FILE: sv/uttc_ctrl.sv
module uttc_ctrl
  import uttc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  uttc_sts_t sts,
  output uttc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MONTH = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] shift_r, shift_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] phase_after;

  always_comb begin
    unique case (phase_r)
      PH_DAY:  phase_after = PH_HOUR;
      PH_HOUR: phase_after = PH_MIN;
      PH_MIN:  phase_after = PH_DOW;
      default: phase_after = PH_DAY;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    shift_nxt      = shift_r;
    cmd            = '0;
    cmd.div_phase  = phase_r;
    cmd.div_shift  = shift_r;
    cmd.div_first  = (shift_r == div_top(phase_r));
    cmd.div_end    = (shift_r == 4'd0);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd.year_step = 1'b1;
        if (sts.year_done) begin
          state_nxt = S_DIV;
          phase_nxt = PH_DAY;
          shift_nxt = div_top(PH_DAY);
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (shift_r == 4'd0) begin
          if (phase_r == PH_DOW) begin
            state_nxt = S_MONTH;
          end else begin
            phase_nxt = phase_after;
            shift_nxt = div_top(phase_after);
          end
        end else begin
          shift_nxt = shift_r - 4'd1;
        end
      end
      S_MONTH: begin
        cmd.month_step = 1'b1;
        if (sts.month_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_DAY;
      shift_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: sv/uttc_dp.sv
module uttc_dp
  import uttc_pkg::*;
(
  input  logic        clk,
  input  uttc_cmd_t   cmd,
  output uttc_sts_t   sts,
  input  logic [31:0] in_timestamp,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday
);

  logic [31:0] ts_r;
  logic [32:0] acc_r;
  logic [11:0] year_r;
  logic [2:0]  ywd_r;
  logic [24:0] w_r;
  logic [8:0]  q_r;
  logic [8:0]  doy_r;
  logic [8:0]  mday_r;
  logic [3:0]  month_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [2:0]  wd_r;

  logic [11:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_minute_r;
  logic [5:0]  out_second_r;
  logic [2:0]  out_weekday_r;

  logic        leap;
  logic [32:0] acc_sum;
  logic [31:0] ts_left;
  logic [3:0]  ywd_sum;
  logic [24:0] dvs;
  logic [25:0] trial;
  logic        ge;
  logic [24:0] w_nxt;
  logic [8:0]  q_nxt;
  logic [3:0]  wd_sum;
  logic [4:0]  mlen;

  assign leap    = is_leap(year_r);
  assign acc_sum = acc_r + (leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR);
  assign ts_left = ts_r - acc_r[31:0];
  assign ywd_sum = {1'b0, ywd_r} + (leap ? 4'd2 : 4'd1);

  assign dvs   = {8'd0, div_const(cmd.div_phase)} << cmd.div_shift;
  assign trial = {1'b0, w_r} - {1'b0, dvs};
  assign ge    = !trial[25];
  assign w_nxt = ge ? trial[24:0] : w_r;
  assign q_nxt = cmd.div_first ? {8'd0, ge} : {q_r[7:0], ge};

  assign wd_sum = {1'b0, ywd_r} + {1'b0, w_nxt[2:0]};
  assign mlen   = month_len(month_r, leap);

  assign sts.year_done  = (acc_sum > {1'b0, ts_r});
  assign sts.month_done = (mday_r < {4'd0, mlen});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_r    <= in_timestamp;
      acc_r   <= '0;
      year_r  <= EPOCH_YEAR;
      ywd_r   <= EPOCH_WEEKDAY;
      month_r <= 4'd1;
    end
    if (cmd.year_step) begin
      if (sts.year_done) begin
        w_r <= ts_left[24:0];
      end else begin
        acc_r  <= acc_sum;
        year_r <= year_r + 12'd1;
        ywd_r  <= (ywd_sum >= 4'd7) ? 3'(ywd_sum - 4'd7) : ywd_sum[2:0];
      end
    end
    if (cmd.div_step) begin
      q_r <= q_nxt;
      // Reload the day of year for the weekday phase.
      if (cmd.div_end && (cmd.div_phase == PH_MIN)) begin
        w_r <= {16'd0, doy_r};
      end else begin
        w_r <= w_nxt;
      end
      if (cmd.div_end) begin
        unique case (cmd.div_phase)
          PH_DAY: begin
            doy_r  <= q_nxt;
            mday_r <= q_nxt;
          end
          PH_HOUR: begin
            hour_r <= q_nxt[4:0];
          end
          PH_MIN: begin
            minute_r <= q_nxt[5:0];
            second_r <= w_nxt[5:0];
          end
          default: begin
            wd_r <= (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
          end
        endcase
      end
    end
    if (cmd.month_step && !sts.month_done) begin
      mday_r  <= mday_r - {4'd0, mlen};
      month_r <= month_r + 4'd1;
    end
    if (cmd.out_load) begin
      out_year_r    <= year_r;
      out_month_r   <= month_r;
      out_day_r     <= mday_r[4:0] + 5'd1;
      out_hour_r    <= hour_r;
      out_minute_r  <= minute_r;
      out_second_r  <= second_r;
      out_weekday_r <= wd_r + 3'd1;
    end
  end

  assign out_year    = out_year_r;
  assign out_month   = out_month_r;
  assign out_day     = out_day_r;
  assign out_hour    = out_hour_r;
  assign out_minute  = out_minute_r;
  assign out_second  = out_second_r;
  assign out_weekday = out_weekday_r;

endmodule

FILE: sv/unix_time_to_calendar.sv
// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_stall   timestamp[31:0]
// out_      result     out_valid/out_stall year, month, day, hour, minute, second, weekday
//
// A request runs through the year walk, one year per cycle over the whole years since
// 1970 (0..136), four divide phases and the month walk over the whole months passed in
// the year (0..11), and is then loaded into the output register.
// Reset (rst_n low, synchronous) clears the controller and drops any pending result.
// in_stall is high while a request is in flight. A finished result waits in the
// output register under out_stall while the next request is already taken.
`include "unix_time_to_calendar_defines.svh"

module unix_time_to_calendar
  import uttc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday
);

  uttc_cmd_t cmd;
  uttc_sts_t sts;

  // Sequencer: year walk, four divide phases on the shared compare-subtract
  // unit (days, hours, minutes, weekday of the day of year), then month walk.
  uttc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: year accumulator, divide unit, month walk and output register.
  uttc_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .in_timestamp (in_timestamp),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .out_hour     (out_hour),
    .out_minute   (out_minute),
    .out_second   (out_second),
    .out_weekday  (out_weekday)
  );

  // Hold off new requests once one is taken.
  `UTTC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // Never overwrite a result that is still waiting.
  `UTTC_ASSERT_IMPLY(a_no_overwrite, cmd.out_load, !out_valid || !out_stall)
  // A presented result is a legal calendar instant.
  `UTTC_ASSERT_IMPLY(a_fields_legal, out_valid,
    out_month != 4'd0 && out_month <= 4'd12 && out_day != 5'd0 &&
    out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59 &&
    out_weekday != 3'd0)

endmodule

FILE: verif/unix_time_to_calendar_tb.sv
module unix_time_to_calendar_tb;

  // Calendar constants, kept local so the predictor stands on its own.
  localparam int unsigned COMMON_YEAR_SECS = 31536000;
  localparam int unsigned DAY_SECS         = 86400;
  localparam int unsigned HOUR_SECS        = 3600;
  localparam int unsigned FIRST_YEAR       = 1970;
  localparam int unsigned MONTH_DAYS[12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Run shape: directed requests, then about a thousand random ones.
  localparam int RANDOM_REQUESTS = 1030;
  localparam int QUIET_TAIL      = 120;   // last requests run with no idling on either side
  localparam int LONG_HOLD       = 1500;  // cycles the result side holds off once
  localparam int HOLD_AFTER      = 300;   // requests accepted before the long hold-off
  localparam int DRAIN_CYCLES    = 200;   // cycles to let the block settle once every date is in
  localparam int DRAIN_LIMIT     = 100000;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  // Full Gregorian rule: every fourth year, but not centuries unless divisible by 400.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Predict the calendar date and weekday for one timestamp.
  function automatic calendar_t to_calendar(input logic [31:0] ts);
    calendar_t   c;
    logic [32:0] acc;
    logic [32:0] prev;
    int unsigned y;
    int unsigned rem;
    int unsigned days;
    int unsigned tod;
    int unsigned mon;
    int unsigned len;
    int unsigned wy;
    int unsigned wm;
    int unsigned sum;
    acc  = '0;
    prev = '0;
    y    = FIRST_YEAR;
    // Walk whole years until the year end passes the timestamp.
    while (acc <= {1'b0, ts}) begin
      prev = acc;
      acc  = acc + COMMON_YEAR_SECS + (leap_year(y) ? DAY_SECS : 0);
      y++;
    end
    y--;
    rem  = ts - prev[31:0];
    days = rem / DAY_SECS;
    tod  = rem % DAY_SECS;
    // Walk the months; December catches whatever is left.
    mon = 12;
    for (int i = 0; i < 12; i++) begin
      len = MONTH_DAYS[i];
      if (i == 1 && leap_year(y)) len = 29;
      if (days < len) begin
        mon = i + 1;
        break;
      end
      days -= len;
    end
    days += 1;
    // Weekday: January and February count as months 13 and 14 of the year before.
    wy = y;
    wm = mon;
    if (wm <= 2) begin
      wm += 12;
      wy -= 1;
    end
    sum = days + 2 * wm + (3 * (wm + 1)) / 5 + wy + wy / 4 - wy / 100 + wy / 400;
    c.year    = y[11:0];
    c.month   = mon[3:0];
    c.day     = days[4:0];
    c.hour    = 5'(tod / HOUR_SECS);
    c.minute  = 6'((tod % HOUR_SECS) / 60);
    c.second  = 6'(tod % 60);
    c.weekday = 3'(sum % 7 + 1);
    return c;
  endfunction

  // Holds the dates still owed by the block, oldest first.
  class calendar_scoreboard;
    calendar_t   expected_dates[$];
    int unsigned failures;
    int unsigned noted;
    int unsigned checked;
    int unsigned first_year = 4095;
    int unsigned last_year;

    function void note_request(input logic [31:0] ts);
      calendar_t c;
      c = to_calendar(ts);
      expected_dates.push_back(c);
      noted++;
      if (c.year < first_year) first_year = c.year;
      if (c.year > last_year) last_year = c.year;
    endfunction

    function void compare_field(input string name, input int unsigned exp,
                                input int unsigned act);
      if (exp != act) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp, act);
        failures++;
      end
    endfunction

    function void check_result(input calendar_t got);
      calendar_t exp;
      if (expected_dates.size() == 0) begin
        $error("result with no request outstanding: %0d-%0d-%0d", got.year, got.month,
               got.day);
        failures++;
        return;
      end
      exp = expected_dates.pop_front();
      checked++;
      compare_field("year",    exp.year,    got.year);
      compare_field("month",   exp.month,   got.month);
      compare_field("day",     exp.day,     got.day);
      compare_field("hour",    exp.hour,    got.hour);
      compare_field("minute",  exp.minute,  got.minute);
      compare_field("second",  exp.second,  got.second);
      compare_field("weekday", exp.weekday, got.weekday);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_timestamp = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;

  calendar_scoreboard sb = new();
  bit quiet;        // set for the tail of the run: no idling on either side
  bit held_long;    // the long result hold-off has happened

  unix_time_to_calendar u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_timestamp (in_timestamp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .out_hour     (out_hour),
    .out_minute   (out_minute),
    .out_second   (out_second),
    .out_weekday  (out_weekday)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one request, optionally after an idle burst, and hold it until taken.
  // Leaves the caller at the edge where the request was accepted.
  task automatic send_request(input logic [31:0] ts, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_timestamp <= ts;
    do @(posedge clk); while (in_stall);
    sb.note_request(ts);
  endtask

  // Pick a random instant: plain 32-bit values, instants close to a year start
  // or on a day boundary, and values near either end of the range.
  function automatic logic [31:0] random_instant();
    int unsigned y;
    logic [31:0] start;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom;
      4, 5: begin
        y     = $urandom_range(FIRST_YEAR, 2106);
        start = '0;
        for (int unsigned k = FIRST_YEAR; k < y; k++)
          start += COMMON_YEAR_SECS + (leap_year(k) ? DAY_SECS : 0);
        // Land within two days either side of New Year.
        return start + $urandom_range(0, 4 * DAY_SECS) - 2 * DAY_SECS;
      end
      6: begin
        // Day boundaries somewhere in a random year.
        start = $urandom;
        start = start - start % DAY_SECS;
        return start - $urandom_range(0, 1);
      end
      default: return $urandom_range(0, 1) ? $urandom_range(0, 200000)
                                            : 32'hFFFF_FFFF - $urandom_range(0, 200000);
    endcase
  endfunction

  // Stimulus: reset, directed corner instants, then random requests.
  initial begin
    logic [31:0] corners[$];
    int          guard;
    corners = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000,     // end of 1970, start of 1971
      32'd68169600,                   // leap day 1972
      32'd94694399,                   // last second of leap year 1972
      32'd951782400,                  // leap day 2000, a century divisible by 400
      32'd978307199, 32'd978307200,   // turn of 2000 into 2001
      32'd2147483647, 32'd2147483648, // signed 32-bit rollover
      32'd4107542399, 32'd4107542400, // 2100 skips its leap day
      32'd4291747200,                 // start of the last reachable year
      32'hAAAA_AAAA, 32'h5555_5555,
      32'hFFFF_FFFF                   // last representable instant
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corners[i]) send_request(corners[i], 1'b1);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
      // Every third block of fifty requests runs back to back.
      send_request(random_instant(), !quiet && ((i / 50) % 3 != 2));
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed date, then let the block settle.
    guard = 0;
    while (sb.expected_dates.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_dates.size() != 0) begin
      $error("%0d dates never came out of the block", sb.expected_dates.size());
      sb.failures += sb.expected_dates.size();
    end

    $display("Converted %0d timestamps (%0d corner instants), years %0d to %0d,",
             sb.checked, corners.size(), sb.first_year, sb.last_year);
    $display("with random idling on both sides and one %0d-cycle result hold-off.",
             LONG_HOLD);
    if (sb.failures == 0) begin
      $display("unix_time_to_calendar test passed");
    end else begin
      $display("unix_time_to_calendar test failed");
    end
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off once traffic is
  // flowing so the output register fills and the block stalls its input.
  initial begin
    wait (rst_n);
    forever begin
      if (!held_long && sb.noted >= HOLD_AFTER) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
      // Advance through a stretch with the stall low.
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Check every date the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_year, out_month, out_day, out_hour, out_minute, out_second,
                        out_weekday});
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #15_000_000;
    $display("unix_time_to_calendar test failed");
    $finish;
  end

endmodule
